// ----- sv/tfst_pkg.sv -----
`timescale 1ns / 1ps

package tfst_pkg;

  // Default flow table depth.
  localparam int FLOW_ENTRIES_DEF = 64;

  // Field widths fixed by the packet header format.
  localparam int LEN_W   = 16;
  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int SEQ_W   = 32;
  localparam int EV_W    = 3;
  localparam int PROG_W  = 2;
  localparam int SLOT_W  = 6;

  // Packet filter constants.
  localparam logic [LEN_W-1:0] MIN_CAP_RESET = 16'd50;
  localparam logic [15:0]      ETH_IPV4      = 16'h0800;
  localparam logic [3:0]       IP_V4         = 4'd4;
  localparam logic [7:0]       PROTO_TCP     = 8'd6;

  // Positions of the flags of interest in the TCP flags byte.
  localparam int FLAG_SYN_BIT = 1;
  localparam int FLAG_ACK_BIT = 4;

  // Event codes.
  localparam logic [EV_W-1:0] EV_IGNORED   = 3'd0;
  localparam logic [EV_W-1:0] EV_DATA      = 3'd1;
  localparam logic [EV_W-1:0] EV_NEW_FLOW  = 3'd2;
  localparam logic [EV_W-1:0] EV_EXTRA_SYN = 3'd3;
  localparam logic [EV_W-1:0] EV_SYNACK    = 3'd4;
  localparam logic [EV_W-1:0] EV_ORPHAN    = 3'd5;
  localparam logic [EV_W-1:0] EV_FULL      = 3'd6;

  // Progress codes.
  localparam logic [PROG_W-1:0] PROG_NONE = 2'd0;
  localparam logic [PROG_W-1:0] PROG_SEND = 2'd1;
  localparam logic [PROG_W-1:0] PROG_RECV = 2'd2;

  // Connection 4-tuple as stored in the table.
  typedef struct packed {
    logic [ADDR_W-1:0] saddr;
    logic [ADDR_W-1:0] daddr;
    logic [PORT_W-1:0] sport;
    logic [PORT_W-1:0] dport;
  } key_t;

  // Table write strobes for one processed packet.
  typedef struct packed {
    logic ins_en;
    logic fwd_wr_en;
    logic rev_wr_en;
  } wr_ctl_t;

  // Result payload without the slot number.
  typedef struct packed {
    logic [EV_W-1:0]   event_res;
    logic [PROG_W-1:0] progress;
    logic [SEQ_W-1:0]  byte_count;
  } result_t;

endpackage

// ----- sv/tfst_flow_table.sv -----
`timescale 1ns / 1ps

module tfst_flow_table #(
  parameter int FLOW_ENTRIES = tfst_pkg::FLOW_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Lookup of the packet being accepted.
  input  tfst_pkg::key_t                    fw_key,
  input  tfst_pkg::key_t                    rv_key,
  output logic [FLOW_ENTRIES-1:0]           fw_hit,
  output logic [FLOW_ENTRIES-1:0]           rv_hit,
  // Read of the packet being processed, selected by its registered match lines.
  input  logic [FLOW_ENTRIES-1:0]           fw_sel,
  input  logic [FLOW_ENTRIES-1:0]           rv_sel,
  output logic [$clog2(FLOW_ENTRIES)-1:0]   fw_idx,
  output logic [$clog2(FLOW_ENTRIES)-1:0]   rv_idx,
  output logic [tfst_pkg::SEQ_W-1:0]        fw_seq,
  output logic [tfst_pkg::SEQ_W-1:0]        rv_seq,
  output logic [$clog2(FLOW_ENTRIES)-1:0]   ins_slot,
  output logic                              full,
  // Write side.
  input  tfst_pkg::wr_ctl_t                 wr,
  input  tfst_pkg::key_t                    ins_key,
  input  logic [tfst_pkg::SEQ_W-1:0]        wr_seq,
  input  logic [$clog2(FLOW_ENTRIES)-1:0]   fwd_wr_idx,
  input  logic [$clog2(FLOW_ENTRIES)-1:0]   rev_wr_idx
);
  import tfst_pkg::*;

  localparam int IDX_W = $clog2(FLOW_ENTRIES);
  localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);

  logic [FLOW_ENTRIES-1:0] valid_r;
  key_t                    tuple_r [FLOW_ENTRIES];
  logic [SEQ_W-1:0]        fseq_r  [FLOW_ENTRIES];
  logic [SEQ_W-1:0]        rseq_r  [FLOW_ENTRIES];
  logic [CNT_W-1:0]        used_r;
  logic [CNT_W-1:0]        used_nxt;

  assign ins_slot = used_r[IDX_W-1:0];
  assign full     = (used_r >= CNT_W'(FLOW_ENTRIES));

  // Parallel match of both tuples. A flow inserted in this same cycle is
  // forwarded so that the packet behind it sees it.
  always_comb begin
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      fw_hit[i] = (valid_r[i] && (tuple_r[i] == fw_key)) ||
                  (wr.ins_en && (ins_slot == IDX_W'(i)) && (ins_key == fw_key));
      rv_hit[i] = (valid_r[i] && (tuple_r[i] == rv_key)) ||
                  (wr.ins_en && (ins_slot == IDX_W'(i)) && (ins_key == rv_key));
    end
  end

  // One-hot read: each entry gates its own index and sequence values.
  always_comb begin
    fw_idx = '0;
    rv_idx = '0;
    fw_seq = '0;
    rv_seq = '0;
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      if (fw_sel[i]) begin
        fw_idx = fw_idx | IDX_W'(i);
        fw_seq = fw_seq | fseq_r[i];
      end
      if (rv_sel[i]) begin
        rv_idx = rv_idx | IDX_W'(i);
        rv_seq = rv_seq | rseq_r[i];
      end
    end
  end

  // Entry payload: tuples and sequence numbers, written in place.
  always_ff @(posedge clk) begin
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      if (wr.ins_en && (ins_slot == IDX_W'(i))) begin
        tuple_r[i] <= ins_key;
        fseq_r[i]  <= wr_seq;
        rseq_r[i]  <= '0;
      end else begin
        if (wr.fwd_wr_en && (fwd_wr_idx == IDX_W'(i))) begin
          fseq_r[i] <= wr_seq;
        end
        if (wr.rev_wr_en && (rev_wr_idx == IDX_W'(i))) begin
          rseq_r[i] <= wr_seq;
        end
      end
    end
  end

  // Slots fill in order and are never freed.
  always_comb begin
    used_nxt = used_r;
    if (wr.ins_en) begin
      used_nxt = used_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
    end else begin
      used_r <= used_nxt;
      if (wr.ins_en) begin
        valid_r[ins_slot] <= 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(FLOW_ENTRIES))
    else $error("flow table fill count exceeds depth");

  a_used_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(used_r))
    else $error("valid slots disagree with fill count");

  a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr.ins_en |-> !full)
    else $error("insert into a full flow table");
`endif

endmodule

// ----- sv/tfst_decide.sv -----
`timescale 1ns / 1ps

module tfst_decide #(
  parameter int FLOW_ENTRIES = tfst_pkg::FLOW_ENTRIES_DEF
) (
  input  logic                              fire,
  input  logic                              pass,
  input  logic                              syn,
  input  logic                              ack,
  input  logic [tfst_pkg::SEQ_W-1:0]        seq,
  input  logic                              fw_ok,
  input  logic                              rv_ok,
  input  logic [$clog2(FLOW_ENTRIES)-1:0]   fw_idx,
  input  logic [$clog2(FLOW_ENTRIES)-1:0]   rv_idx,
  input  logic [tfst_pkg::SEQ_W-1:0]        fw_seq,
  input  logic [tfst_pkg::SEQ_W-1:0]        rv_seq,
  input  logic [$clog2(FLOW_ENTRIES)-1:0]   ins_slot,
  input  logic                              full,
  output tfst_pkg::result_t                 res,
  output logic [$clog2(FLOW_ENTRIES)-1:0]   slot,
  output tfst_pkg::wr_ctl_t                 wr,
  output logic [$clog2(FLOW_ENTRIES)-1:0]   fwd_wr_idx,
  output logic [$clog2(FLOW_ENTRIES)-1:0]   rev_wr_idx
);
  import tfst_pkg::*;

  logic             syn_only;
  logic             syn_ack;
  logic             chk;
  logic             fw_gt;
  logic             rv_gt;
  logic [SEQ_W-1:0] fw_delta;
  logic [SEQ_W-1:0] rv_delta;

  assign syn_only   = syn && !ack;
  assign syn_ack    = syn && ack;
  assign fw_gt      = seq > fw_seq;
  assign rv_gt      = seq > rv_seq;
  assign fw_delta   = seq - fw_seq;
  assign rv_delta   = seq - rv_seq;
  assign fwd_wr_idx = fw_idx;
  assign rev_wr_idx = rv_idx;

  // Handshake-flag handling first, then the sequence advance check.
  always_comb begin
    res  = '0;
    slot = '0;
    wr   = '0;
    chk  = 1'b0;
    if (pass) begin
      if (syn_only) begin
        if (fw_ok) begin
          res.event_res = EV_EXTRA_SYN;
          slot          = fw_idx;
        end else if (full) begin
          res.event_res = EV_FULL;
        end else begin
          res.event_res = EV_NEW_FLOW;
          slot          = ins_slot;
          wr.ins_en     = fire;
          chk           = 1'b1;
        end
      end else if (syn_ack) begin
        if (!rv_ok) begin
          res.event_res = EV_ORPHAN;
        end else begin
          res.event_res = EV_SYNACK;
          slot          = rv_idx;
          wr.rev_wr_en  = fire;
          chk           = 1'b1;
        end
      end else begin
        chk = 1'b1;
      end

      // The forward flow wins when both directions match. After a SYN-ACK
      // the reverse value is written from the packet's instead, so no receive advance is reported.
      if (chk) begin
        if (fw_ok) begin
          if (res.event_res == EV_IGNORED) begin
            res.event_res = EV_DATA;
            slot          = fw_idx;
          end
          if (fw_gt) begin
            res.progress   = PROG_SEND;
            res.byte_count = fw_delta;
            wr.fwd_wr_en   = fire;
          end
        end else if (rv_ok) begin
          if (res.event_res == EV_IGNORED) begin
            res.event_res = EV_DATA;
            slot          = rv_idx;
          end
          if (rv_gt && !syn_ack) begin
            res.progress   = PROG_RECV;
            res.byte_count = rv_delta;
            wr.rev_wr_en   = fire;
          end
        end
      end
    end
  end

endmodule

// ----- sv/tcp_flow_sequence_tracker_unit.sv -----
`timescale 1ns / 1ps

// A result passes through the lookup stage registers, then the result register.
// Throughput: one packet header per cycle while the output is not stalled; the table
// match runs on intake, the update in the lookup stage; same-cycle inserts are forwarded.
// Reset: flow table emptied (valid bits and fill count cleared at once), pipeline
// flushed, min_capture_length set to 50. No clearing pass is needed.
module tcp_flow_sequence_tracker_unit #(
  parameter int FLOW_ENTRIES = tfst_pkg::FLOW_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration: min_capture_length.
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  // Input header stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata, low bit up: capture_length[15:0], eth_type[31:16], ip_version[35:32],
  // ip_protocol[43:36], source_address[75:44], destination_address[107:76],
  // source_port[123:108], destination_port[139:124], tcp_flag_bits[147:140],
  // sequence_number[179:148], zero fill[183:180].
  input  logic [183:0] in_tdata,
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata, low bit up: progress[1:0], byte_count[33:2], flow_slot[39:34].
  output logic [39:0]  out_tdata,
  // tuser: event_res[2:0].
  output logic [2:0]   out_tuser
);
  import tfst_pkg::*;

  localparam int IDX_W = $clog2(FLOW_ENTRIES);
  localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  // Input field views.
  logic [LEN_W-1:0]  in_caplen;
  logic [15:0]       in_etype;
  logic [3:0]        in_ver;
  logic [7:0]        in_proto;
  logic [7:0]        in_flags;
  logic [SEQ_W-1:0]  in_seq;
  key_t              in_fw_key;
  key_t              in_rv_key;
  logic              in_pass;

  // Configuration register.
  logic [LEN_W-1:0]  min_cap_r;

  // Lookup stage registers.
  logic                    a_valid_r;
  logic                    a_pass_r;
  logic                    a_syn_r;
  logic                    a_ack_r;
  logic [SEQ_W-1:0]        a_seq_r;
  key_t                    a_key_r;
  logic [FLOW_ENTRIES-1:0] a_fw_hit_r;
  logic [FLOW_ENTRIES-1:0] a_rv_hit_r;
  logic                    a_adv;
  logic                    a_fire;

  // Table interface.
  logic [FLOW_ENTRIES-1:0] fw_hit;
  logic [FLOW_ENTRIES-1:0] rv_hit;
  logic [IDX_W-1:0]        fw_idx;
  logic [IDX_W-1:0]        rv_idx;
  logic [SEQ_W-1:0]        fw_seq;
  logic [SEQ_W-1:0]        rv_seq;
  logic [IDX_W-1:0]        ins_slot;
  logic                    full;
  wr_ctl_t                 wr;
  logic [IDX_W-1:0]        fwd_wr_idx;
  logic [IDX_W-1:0]        rev_wr_idx;

  // Update result and output registers.
  result_t                 res;
  logic [IDX_W-1:0]        slot;
  logic [EXT_W-1:0]        slot_ext;
  logic                    out_valid_r;
  result_t                 out_res_r;
  logic [SLOT_W-1:0]       out_slot_r;

  // Unpack the header and apply the packet filter.
  assign in_caplen       = in_tdata[15:0];
  assign in_etype        = in_tdata[31:16];
  assign in_ver          = in_tdata[35:32];
  assign in_proto        = in_tdata[43:36];
  assign in_fw_key.saddr = in_tdata[75:44];
  assign in_fw_key.daddr = in_tdata[107:76];
  assign in_fw_key.sport = in_tdata[123:108];
  assign in_fw_key.dport = in_tdata[139:124];
  assign in_flags        = in_tdata[147:140];
  assign in_seq          = in_tdata[179:148];

  assign in_rv_key.saddr = in_fw_key.daddr;
  assign in_rv_key.daddr = in_fw_key.saddr;
  assign in_rv_key.sport = in_fw_key.dport;
  assign in_rv_key.dport = in_fw_key.sport;

  assign in_pass = (in_caplen >= min_cap_r) && (in_etype == ETH_IPV4) &&
                   (in_ver == IP_V4) && (in_proto == PROTO_TCP);

  // Configuration write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_cap_r <= MIN_CAP_RESET;
    end else if (cfg_wr_en) begin
      min_cap_r <= cfg_wr_data;
    end
  end

  // Pipeline flow control: the lookup stage moves on when the output
  // register is empty or its transfer completes.
  assign a_adv     = !out_valid_r || out_tready;
  assign a_fire    = a_valid_r && a_adv;
  assign in_tready = !a_valid_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_pass_r   <= in_pass;
      a_syn_r    <= in_flags[FLAG_SYN_BIT];
      a_ack_r    <= in_flags[FLAG_ACK_BIT];
      a_seq_r    <= in_seq;
      a_key_r    <= in_fw_key;
      a_fw_hit_r <= fw_hit;
      a_rv_hit_r <= rv_hit;
    end
  end

  tfst_flow_table #(
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .fw_key     (in_fw_key),
    .rv_key     (in_rv_key),
    .fw_hit     (fw_hit),
    .rv_hit     (rv_hit),
    .fw_sel     (a_fw_hit_r),
    .rv_sel     (a_rv_hit_r),
    .fw_idx     (fw_idx),
    .rv_idx     (rv_idx),
    .fw_seq     (fw_seq),
    .rv_seq     (rv_seq),
    .ins_slot   (ins_slot),
    .full       (full),
    .wr         (wr),
    .ins_key    (a_key_r),
    .wr_seq     (a_seq_r),
    .fwd_wr_idx (fwd_wr_idx),
    .rev_wr_idx (rev_wr_idx)
  );

  tfst_decide #(
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_decide (
    .fire       (a_fire),
    .pass       (a_pass_r),
    .syn        (a_syn_r),
    .ack        (a_ack_r),
    .seq        (a_seq_r),
    .fw_ok      (|a_fw_hit_r),
    .rv_ok      (|a_rv_hit_r),
    .fw_idx     (fw_idx),
    .rv_idx     (rv_idx),
    .fw_seq     (fw_seq),
    .rv_seq     (rv_seq),
    .ins_slot   (ins_slot),
    .full       (full),
    .res        (res),
    .slot       (slot),
    .wr         (wr),
    .fwd_wr_idx (fwd_wr_idx),
    .rev_wr_idx (rev_wr_idx)
  );

  // Result register.
  assign slot_ext = EXT_W'(slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_adv) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      out_res_r  <= res;
      out_slot_r <= slot_ext[SLOT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_slot_r, out_res_r.byte_count, out_res_r.progress};
  assign out_tuser  = out_res_r.event_res;

`ifndef ASSERT_OFF
  a_fw_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |-> $onehot0(a_fw_hit_r))
    else $error("forward tuple matched more than one slot");

  a_rv_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |-> $onehot0(a_rv_hit_r))
    else $error("reverse tuple matched more than one slot");

  a_ignored_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == EV_IGNORED)) |-> (out_tdata == '0))
    else $error("ignored packet carries a nonzero result");

  a_progress_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] != PROG_NONE)) |-> (out_tdata[33:2] != '0))
    else $error("sequence advance reported with zero bytes");
`endif

endmodule
